// ===== design/frame_timestep_accumulator_assert.svh =====
// Assertion macros for the frame timestep accumulator.
// The macros expect signals named clk and rst_n in the calling scope.
`ifndef FRAME_TIMESTEP_ACCUMULATOR_ASSERT_SVH
`define FRAME_TIMESTEP_ACCUMULATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define FTSA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftsa assertion failed");

// Next-cycle implication
`define FTSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftsa assertion failed");

`else

`define FTSA_ASSERT_NOW(lbl, ante, cons)
`define FTSA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/ftsa_pkg.sv =====
package ftsa_pkg;

    // Sizes
    localparam int MAX_WINDOW = 16;
    localparam int MAX_STEPS  = 5;
    localparam int DELTA_BITS = 24;
    localparam int PTR_BITS   = $clog2(MAX_WINDOW);
    localparam int FILL_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS   = DELTA_BITS + PTR_BITS;
    localparam int ACC_BITS   = 32;
    localparam int TOTAL_BITS = 48;
    localparam int SCALE_BITS = 16;
    localparam int COUNT_BITS = 3;
    localparam int CFG_BITS   = 24;
    localparam int DIV_BITS   = DELTA_BITS;
    localparam int DIV_NUM_BITS = 2 * DIV_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

    // Timing modes; code three behaves as variable
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_VARIABLE   = 2'd0;
    localparam mode_t MODE_FIXED      = 2'd1;
    localparam mode_t MODE_SEMI_FIXED = 2'd2;

    // Register indexes
    typedef enum logic [2:0] {
        CFG_TIMING_MODE      = 3'd0,
        CFG_PAUSED           = 3'd1,
        CFG_MAX_DELTA        = 3'd2,
        CFG_TIME_SCALE       = 3'd3,
        CFG_FIXED_STEP       = 3'd4,
        CFG_SMOOTHING_WINDOW = 3'd5
    } cfg_idx_t;

    // Reset values
    localparam logic [DELTA_BITS-1:0] RST_MAX_DELTA  = 24'd250000;
    localparam logic [SCALE_BITS-1:0] RST_TIME_SCALE = 16'd256;
    localparam logic [DELTA_BITS-1:0] RST_FIXED_STEP = 24'd16667;
    localparam logic [4:0]            RST_WINDOW     = 5'd1;

    // Ring access
    typedef struct packed {
        logic                rd_en;
        logic [PTR_BITS-1:0] rd_addr;
        logic                wr_en;
        logic [PTR_BITS-1:0] wr_addr;
    } ring_ctrl_t;

    // Divider request and response
    typedef struct packed {
        logic                    start;
        logic [DIV_NUM_BITS-1:0] num;
        logic [DIV_BITS-1:0]     den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quot;
    } div_rsp_t;

endpackage

// ===== design/ftsa_ring.sv =====
module ftsa_ring
    import ftsa_pkg::*;
(
    input  logic                  clk,
    input  ring_ctrl_t            ctrl,
    input  logic [DELTA_BITS-1:0] wr_data,
    output logic [DELTA_BITS-1:0] rd_data
);

    logic [DELTA_BITS-1:0] mem [MAX_WINDOW];
    logic [DELTA_BITS-1:0] rd_data_reg;

    // History store, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ftsa_div.sv =====
module ftsa_div
    import ftsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    // Restoring divider, one quotient bit a cycle.
    // Caller guarantees num[top half] < den, so the quotient fits DIV_BITS.
    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_BITS-1:0]     rem_reg;
    logic [DIV_BITS-1:0]     low_reg;
    logic [DIV_BITS-1:0]     quot_reg;
    logic [DIV_BITS-1:0]     den_reg;
    logic [DIV_BITS:0]       trial;
    logic                    fits;

    assign trial = {rem_reg, low_reg[DIV_BITS-1]} - {1'b0, den_reg};
    assign fits  = !trial[DIV_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            low_reg  <= '0;
            quot_reg <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= req.num[DIV_NUM_BITS-1:DIV_BITS];
                low_reg  <= req.num[DIV_BITS-1:0];
                den_reg  <= req.den;
                quot_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= trial[DIV_BITS-1:0];
                end
                else
                begin
                    rem_reg <= {rem_reg[DIV_BITS-2:0], low_reg[DIV_BITS-1]};
                end
                low_reg  <= {low_reg[DIV_BITS-2:0], 1'b0};
                quot_reg <= {quot_reg[DIV_BITS-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(DIV_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== design/frame_timestep_accumulator.sv =====
// Channel  Handshake            Payload
// cfg      cfg_we               cfg_index, cfg_data (write only, no wait)
// in       in_valid/in_ready    frame_delta_us
// out      out_valid/out_ready  clamped_delta_us, smoothed_delta_us, update_count,
//                               interpolation, unscaled_time_us, scaled_time_us
//
// Each beat uses the shared restoring divider, one pass for the average and, in
// fixed modes, one for the interpolation, and in fixed modes the step loop (one
// subtract a cycle, at most five steps). in_ready is high only while idle.
// A finished result waits in the output register; the next beat may be taken
// meanwhile. Reset clears history count, sums, accumulator and registers.
`include "frame_timestep_accumulator_assert.svh"

module frame_timestep_accumulator
    import ftsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DELTA_BITS-1:0] frame_delta_us,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DELTA_BITS-1:0] clamped_delta_us,
    output logic [DELTA_BITS-1:0] smoothed_delta_us,
    output logic [COUNT_BITS-1:0] update_count,
    output logic [DELTA_BITS-1:0] interpolation,
    output logic [TOTAL_BITS-1:0] unscaled_time_us,
    output logic [TOTAL_BITS-1:0] scaled_time_us
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_SM_GO,
        S_SM_WAIT,
        S_MUL,
        S_ACC,
        S_STEP,
        S_INT_GO,
        S_INT_WAIT,
        S_OUT
    } state_t;

    // Configuration registers
    mode_t                 mode_reg;
    logic                  paused_reg;
    logic [DELTA_BITS-1:0] max_delta_reg;
    logic [SCALE_BITS-1:0] scale_reg;
    logic [DELTA_BITS-1:0] step_reg;
    logic [4:0]            window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_VARIABLE;
            paused_reg    <= 1'b0;
            max_delta_reg <= RST_MAX_DELTA;
            scale_reg     <= RST_TIME_SCALE;
            step_reg      <= RST_FIXED_STEP;
            window_reg    <= RST_WINDOW;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TIMING_MODE:      mode_reg      <= cfg_data[1:0];
                CFG_PAUSED:           paused_reg    <= cfg_data[0];
                CFG_MAX_DELTA:        max_delta_reg <= cfg_data[DELTA_BITS-1:0];
                CFG_TIME_SCALE:       scale_reg     <= cfg_data[SCALE_BITS-1:0];
                CFG_FIXED_STEP:
                begin
                    // zero step is ignored
                    if (cfg_data[DELTA_BITS-1:0] != '0)
                    begin
                        step_reg <= cfg_data[DELTA_BITS-1:0];
                    end
                end
                CFG_SMOOTHING_WINDOW: window_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Sequencer state and datapath registers
    state_t                state_reg,   state_next;
    logic [DELTA_BITS-1:0] d_reg,       d_next;
    logic                  drop_reg,    drop_next;
    logic [PTR_BITS-1:0]   wp_reg,      wp_next;
    logic [FILL_BITS-1:0]  fill_reg,    fill_next;
    logic [SUM_BITS-1:0]   sum_reg,     sum_next;
    logic [DELTA_BITS-1:0] sm_reg,      sm_next;
    logic [ACC_BITS-1:0]   eff_reg,     eff_next;
    logic [ACC_BITS-1:0]   acc_reg,     acc_next;
    logic [TOTAL_BITS-1:0] unscaled_reg, unscaled_next;
    logic [TOTAL_BITS-1:0] scaled_reg,  scaled_next;
    logic [COUNT_BITS-1:0] count_reg,   count_next;
    logic [DELTA_BITS-1:0] interp_reg,  interp_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DELTA_BITS-1:0] o_clamped_reg, o_clamped_next;
    logic [DELTA_BITS-1:0] o_sm_reg,    o_sm_next;
    logic [COUNT_BITS-1:0] o_count_reg, o_count_next;
    logic [DELTA_BITS-1:0] o_interp_reg, o_interp_next;
    logic [TOTAL_BITS-1:0] o_unscaled_reg, o_unscaled_next;
    logic [TOTAL_BITS-1:0] o_scaled_reg, o_scaled_next;

    logic                  in_fire;
    logic [DELTA_BITS-1:0] d_in;
    logic [FILL_BITS-1:0]  win;
    logic [DELTA_BITS+SCALE_BITS-1:0] product;
    logic [ACC_BITS:0]     acc_sum;
    logic [ACC_BITS-1:0]   acc_add;
    logic                  fixed_mode;
    logic                  can_step;
    logic                  interp_sat;
    logic [DELTA_BITS-1:0] ring_rd;
    ring_ctrl_t            ring_ctrl;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Pause and clamp
    always_comb
    begin
        d_in = paused_reg ? '0 : frame_delta_us;
        if (d_in > max_delta_reg)
        begin
            d_in = max_delta_reg;
        end
    end

    // Effective window: zero reads as one, large values saturate
    always_comb
    begin
        if (window_reg == '0)
        begin
            win = FILL_BITS'(1);
        end
        else if (window_reg > 5'(MAX_WINDOW))
        begin
            win = FILL_BITS'(MAX_WINDOW);
        end
        else
        begin
            win = FILL_BITS'(window_reg);
        end
    end

    assign fixed_mode = (mode_reg == MODE_FIXED) || (mode_reg == MODE_SEMI_FIXED);
    assign product    = sm_reg * scale_reg;
    assign acc_add    = (mode_reg == MODE_FIXED) ? ACC_BITS'(sm_reg) : eff_reg;
    assign acc_sum    = {1'b0, acc_reg} + {1'b0, acc_add};
    assign can_step   = (acc_reg >= ACC_BITS'(step_reg)) && (count_reg != COUNT_BITS'(MAX_STEPS));
    assign interp_sat = acc_reg >= {step_reg, 8'b0};

    // Ring: read the oldest entry on accept, write the new one in the push cycle
    always_comb
    begin
        ring_ctrl.rd_en   = in_fire;
        ring_ctrl.rd_addr = wp_reg - fill_reg[PTR_BITS-1:0];
        ring_ctrl.wr_en   = (state_reg == S_PUSH);
        ring_ctrl.wr_addr = wp_reg;
    end

    // Divider requests: average first, interpolation second
    always_comb
    begin
        div_req.start = (state_reg == S_SM_GO) || (state_reg == S_INT_GO);
        if (state_reg == S_INT_GO)
        begin
            div_req.num = {acc_reg, 16'b0};
            div_req.den = step_reg;
        end
        else
        begin
            div_req.num = DIV_NUM_BITS'(sum_reg);
            div_req.den = DIV_BITS'(fill_reg);
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        d_next          = d_reg;
        drop_next       = drop_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        sum_next        = sum_reg;
        sm_next         = sm_reg;
        eff_next        = eff_reg;
        acc_next        = acc_reg;
        unscaled_next   = unscaled_reg;
        scaled_next     = scaled_reg;
        count_next      = count_reg;
        interp_next     = interp_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        o_clamped_next  = o_clamped_reg;
        o_sm_next       = o_sm_reg;
        o_count_next    = o_count_reg;
        o_interp_next   = o_interp_reg;
        o_unscaled_next = o_unscaled_reg;
        o_scaled_next   = o_scaled_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    d_next     = d_in;
                    drop_next  = (fill_reg >= win);
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                sum_next   = sum_reg - (drop_reg ? SUM_BITS'(ring_rd) : '0)
                             + SUM_BITS'(d_reg);
                fill_next  = fill_reg - FILL_BITS'(drop_reg) + 1'b1;
                wp_next    = wp_reg + 1'b1;
                state_next = S_SM_GO;
            end
            S_SM_GO:
            begin
                state_next = S_SM_WAIT;
            end
            S_SM_WAIT:
            begin
                if (div_rsp.done)
                begin
                    sm_next    = div_rsp.quot;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                eff_next   = product[DELTA_BITS+SCALE_BITS-1:8];
                state_next = S_ACC;
            end
            S_ACC:
            begin
                unscaled_next = unscaled_reg + TOTAL_BITS'(sm_reg);
                scaled_next   = scaled_reg + TOTAL_BITS'(eff_reg);
                if (fixed_mode)
                begin
                    acc_next   = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
                    count_next = '0;
                    state_next = S_STEP;
                end
                else
                begin
                    count_next  = COUNT_BITS'(1);
                    interp_next = '0;
                    state_next  = S_OUT;
                end
            end
            S_STEP:
            begin
                // one step taken out per cycle
                if (can_step)
                begin
                    acc_next   = acc_reg - ACC_BITS'(step_reg);
                    count_next = count_reg + 1'b1;
                end
                else if (interp_sat)
                begin
                    interp_next = '1;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_INT_GO;
                end
            end
            S_INT_GO:
            begin
                state_next = S_INT_WAIT;
            end
            S_INT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    interp_next = div_rsp.quot;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                // load the output stage once the previous beat has gone
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    o_clamped_next  = d_reg;
                    o_sm_next       = sm_reg;
                    o_count_next    = count_reg;
                    o_interp_next   = interp_reg;
                    o_unscaled_next = unscaled_reg;
                    o_scaled_next   = scaled_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            d_reg          <= '0;
            drop_reg       <= 1'b0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            sm_reg         <= '0;
            eff_reg        <= '0;
            acc_reg        <= '0;
            unscaled_reg   <= '0;
            scaled_reg     <= '0;
            count_reg      <= '0;
            interp_reg     <= '0;
            out_valid_reg  <= 1'b0;
            o_clamped_reg  <= '0;
            o_sm_reg       <= '0;
            o_count_reg    <= '0;
            o_interp_reg   <= '0;
            o_unscaled_reg <= '0;
            o_scaled_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            d_reg          <= d_next;
            drop_reg       <= drop_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            sum_reg        <= sum_next;
            sm_reg         <= sm_next;
            eff_reg        <= eff_next;
            acc_reg        <= acc_next;
            unscaled_reg   <= unscaled_next;
            scaled_reg     <= scaled_next;
            count_reg      <= count_next;
            interp_reg     <= interp_next;
            out_valid_reg  <= out_valid_next;
            o_clamped_reg  <= o_clamped_next;
            o_sm_reg       <= o_sm_next;
            o_count_reg    <= o_count_next;
            o_interp_reg   <= o_interp_next;
            o_unscaled_reg <= o_unscaled_next;
            o_scaled_reg   <= o_scaled_next;
        end
    end

    ftsa_ring u_ring
    (
        .clk     (clk),
        .ctrl    (ring_ctrl),
        .wr_data (d_reg),
        .rd_data (ring_rd)
    );

    ftsa_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid         = out_valid_reg;
    assign clamped_delta_us  = o_clamped_reg;
    assign smoothed_delta_us = o_sm_reg;
    assign update_count      = o_count_reg;
    assign interpolation     = o_interp_reg;
    assign unscaled_time_us  = o_unscaled_reg;
    assign scaled_time_us    = o_scaled_reg;

    // Checks
    `FTSA_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_BITS'(MAX_WINDOW))
    `FTSA_ASSERT_NOW(a_count_bound, out_valid, update_count <= COUNT_BITS'(MAX_STEPS))
    `FTSA_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
    `FTSA_ASSERT_NOW(a_div_only_waiting, div_rsp.done,
        state_reg == S_SM_WAIT || state_reg == S_INT_WAIT)

endmodule
